@@ design/csp_pkg.sv @@
// Package for the content placement block: request and response types,
// scale mode codes, status codes and internal placement kinds. No dependencies.
package csp_pkg;

    // Scale modes
    localparam logic [3:0] MODE_FILL        = 4'd0;
    localparam logic [3:0] MODE_CENTER      = 4'd1;
    localparam logic [3:0] MODE_FIT_ASPECT  = 4'd2;
    localparam logic [3:0] MODE_COVER_CLIP  = 4'd3;
    localparam logic [3:0] MODE_FIT_CENTER  = 4'd4;
    localparam logic [3:0] MODE_FILL_X      = 4'd5;
    localparam logic [3:0] MODE_FIT_X       = 4'd6;
    localparam logic [3:0] MODE_FILL_Y      = 4'd7;
    localparam logic [3:0] MODE_FIT_Y       = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;
    localparam logic [1:0] ST_BAD_MODE = 2'd3;

    // Placement kind chosen once the mode has been decoded
    localparam logic [2:0] KIND_FILL    = 3'd0;
    localparam logic [2:0] KIND_CENTER  = 3'd1;
    localparam logic [2:0] KIND_SCALE_X = 3'd2;
    localparam logic [2:0] KIND_SCALE_Y = 3'd3;
    localparam logic [2:0] KIND_DIV0    = 3'd4;
    localparam logic [2:0] KIND_BAD     = 3'd5;

    // Quotient bits of the scaled dimension
    localparam int DIV_BITS = 30;
    // Internal signed width for positions and sizes
    localparam int IW = 34;

    typedef struct packed {
        logic [3:0]         scale_mode;
        logic signed [15:0] bounds_x;
        logic signed [15:0] bounds_y;
        logic [14:0]        bounds_width;
        logic [14:0]        bounds_height;
        logic [14:0]        content_width;
        logic [14:0]        content_height;
    } csp_req_t;

    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic [1:0]         status;
    } csp_rsp_t;

    // Context carried alongside the divider
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [14:0]        bw;
        logic [14:0]        bh;
        logic [14:0]        cw;
        logic [14:0]        ch;
    } csp_ctx_t;

endpackage

@@ design/content_scale_placement.sv @@
// Top level of the content placement block: a fully pipelined placement unit.
// Depends on csp_pkg for payload types, mode, kind and status codes.
//
// Usage: a request on req/req_valid carries a scale mode, a bounds rectangle
// and the natural content size. One response on rsp/rsp_valid returns the
// placed rectangle and a status (ok, zero divisor, saturated, unknown mode).
// A request is taken on a rising edge with req_valid high and req_stall low;
// a response is taken with rsp_valid high and rsp_stall low.
// Throughput is one request per cycle unless the receiver stalls. A request
// passes to rsp_valid through 35 register stages: one stage forms the two cross
// products, one decodes the mode, thirty stages run a restoring divider one
// quotient bit each, two stages size and center the rectangle, and one clamps
// into the output register.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears every stage valid bit; no response is pending afterwards.
// COORD_BITS sets the saturation range of positions and sizes.
module content_scale_placement
    import csp_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  csp_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output csp_rsp_t rsp
);

    localparam logic signed [IW-1:0] CMAX = (IW'(1) << (COORD_BITS - 1)) - IW'(1);
    localparam logic signed [IW-1:0] CMIN = -CMAX - IW'(1);

    logic adv;

    // Stage 1: request capture and cross products
    logic        v1_reg;
    csp_req_t    r1_reg;
    logic [29:0] p_cb_reg;
    logic [29:0] p_bc_reg;

    // Divider stages, index 0 is the mode decode stage
    logic        dv_reg  [0:DIV_BITS];
    csp_ctx_t    dc_reg  [0:DIV_BITS];
    logic [29:0] dq_reg  [0:DIV_BITS];
    logic [14:0] dr_reg  [0:DIV_BITS];
    logic [14:0] dd_reg  [0:DIV_BITS];

    // Sizing stage
    logic                 va_reg;
    csp_ctx_t             ca_reg;
    logic signed [IW-1:0] wa_reg;
    logic signed [IW-1:0] ha_reg;

    // Centering stage
    logic                 vb_reg;
    logic [2:0]           kb_reg;
    logic signed [IW-1:0] xb_reg;
    logic signed [IW-1:0] yb_reg;
    logic signed [IW-1:0] wb_reg;
    logic signed [IW-1:0] hb_reg;

    // Output stage
    logic     vo_reg;
    csp_rsp_t rsp_reg;

    // The pipeline moves as one unless a finished response is held.
    assign adv       = !(vo_reg && rsp_stall);
    assign req_stall = !adv;
    assign rsp_valid = vo_reg;
    assign rsp       = rsp_reg;

    // Stage 1 products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg   <= req;
            p_cb_reg <= 30'(req.content_width) * 30'(req.bounds_height);
            p_bc_reg <= 30'(req.bounds_width) * 30'(req.content_height);
        end
    end

    // Mode decode: pick the placement kind, numerator and divisor.
    logic     widex;
    logic     axis_x;
    logic     use_div;
    logic     fits_x;
    logic     fits_y;
    csp_ctx_t ctx0_next;

    always_comb
    begin
        widex   = (p_cb_reg >= p_bc_reg);
        fits_x  = (r1_reg.content_width <= r1_reg.bounds_width);
        fits_y  = (r1_reg.content_height <= r1_reg.bounds_height);
        axis_x  = 1'b0;
        use_div = 1'b0;
        ctx0_next.bx = r1_reg.bounds_x;
        ctx0_next.by = r1_reg.bounds_y;
        ctx0_next.bw = r1_reg.bounds_width;
        ctx0_next.bh = r1_reg.bounds_height;
        ctx0_next.cw = r1_reg.content_width;
        ctx0_next.ch = r1_reg.content_height;
        ctx0_next.kind = KIND_CENTER;
        case (r1_reg.scale_mode)
            MODE_FILL:       ctx0_next.kind = KIND_FILL;
            MODE_CENTER:     ctx0_next.kind = KIND_CENTER;
            MODE_FIT_ASPECT:
            begin
                use_div = 1'b1;
                axis_x  = widex;
            end
            MODE_COVER_CLIP:
            begin
                use_div = 1'b1;
                axis_x  = !widex;
            end
            MODE_FIT_CENTER:
            begin
                use_div = !(fits_x && fits_y);
                axis_x  = widex;
            end
            MODE_FILL_X:
            begin
                use_div = 1'b1;
                axis_x  = 1'b1;
            end
            MODE_FIT_X:
            begin
                use_div = !fits_x;
                axis_x  = 1'b1;
            end
            MODE_FILL_Y:     use_div = 1'b1;
            MODE_FIT_Y:      use_div = !fits_y;
            default:         ctx0_next.kind = KIND_BAD;
        endcase
        if (use_div)
        begin
            if (axis_x)
            begin
                ctx0_next.kind = (r1_reg.content_width == 15'd0) ? KIND_DIV0 : KIND_SCALE_X;
            end
            else
            begin
                ctx0_next.kind = (r1_reg.content_height == 15'd0) ? KIND_DIV0 : KIND_SCALE_Y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_BITS; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dv_reg[0] <= v1_reg;
            for (int i = 1; i <= DIV_BITS; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    // Restoring divider, one quotient bit per stage; the numerator shifts
    // out of dq while quotient bits shift in.
    logic [15:0] trial [1:DIV_BITS];
    logic [15:0] sub   [1:DIV_BITS];

    always_comb
    begin
        for (int i = 1; i <= DIV_BITS; i++)
        begin
            trial[i] = {dr_reg[i-1], dq_reg[i-1][DIV_BITS-1]};
            sub[i]   = trial[i] - {1'b0, dd_reg[i-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dc_reg[0] <= ctx0_next;
            dq_reg[0] <= axis_x ? p_bc_reg : p_cb_reg;
            dd_reg[0] <= axis_x ? r1_reg.content_width : r1_reg.content_height;
            dr_reg[0] <= 15'd0;
            for (int i = 1; i <= DIV_BITS; i++)
            begin
                dc_reg[i] <= dc_reg[i-1];
                dd_reg[i] <= dd_reg[i-1];
                if (trial[i] >= {1'b0, dd_reg[i-1]})
                begin
                    dr_reg[i] <= sub[i][14:0];
                    dq_reg[i] <= {dq_reg[i-1][DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    dr_reg[i] <= trial[i][14:0];
                    dq_reg[i] <= {dq_reg[i-1][DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Sizing: choose width and height from the kind and the quotient.
    csp_ctx_t             cz;
    logic signed [IW-1:0] quo;
    logic signed [IW-1:0] wa_next;
    logic signed [IW-1:0] ha_next;

    always_comb
    begin
        cz  = dc_reg[DIV_BITS];
        quo = IW'(dq_reg[DIV_BITS]);
        case (cz.kind)
            KIND_SCALE_X:
            begin
                wa_next = IW'(cz.bw);
                ha_next = quo;
            end
            KIND_SCALE_Y:
            begin
                wa_next = quo;
                ha_next = IW'(cz.bh);
            end
            KIND_FILL:
            begin
                wa_next = IW'(cz.bw);
                ha_next = IW'(cz.bh);
            end
            default:
            begin
                wa_next = IW'(cz.cw);
                ha_next = IW'(cz.ch);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= dv_reg[DIV_BITS];
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    // Centering: pos + (bounds - size) / 2, truncating toward zero.
    // The sign bit is added back as a signed one so the shift stays arithmetic.
    logic signed [IW-1:0] dx;
    logic signed [IW-1:0] dy;
    logic signed [IW-1:0] hx;
    logic signed [IW-1:0] hy;

    always_comb
    begin
        dx = IW'(ca_reg.bw) - wa_reg;
        dy = IW'(ca_reg.bh) - ha_reg;
        hx = (dx + $signed(IW'(dx[IW-1]))) >>> 1;
        hy = (dy + $signed(IW'(dy[IW-1]))) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca_reg <= cz;
            wa_reg <= wa_next;
            ha_reg <= ha_next;
            kb_reg <= ca_reg.kind;
            wb_reg <= wa_reg;
            hb_reg <= ha_reg;
            xb_reg <= IW'(ca_reg.bx) + hx;
            yb_reg <= IW'(ca_reg.by) + hy;
        end
    end

    // Clamp into the coordinate range and form the status.
    logic signed [IW-1:0] xc;
    logic signed [IW-1:0] yc;
    logic signed [IW-1:0] wc;
    logic signed [IW-1:0] hc;
    logic                 sat;
    csp_rsp_t             rsp_next;

    always_comb
    begin
        sat = 1'b0;
        xc  = xb_reg;
        yc  = yb_reg;
        wc  = wb_reg;
        hc  = hb_reg;
        if (xb_reg < CMIN)
        begin
            xc = CMIN;
            sat = 1'b1;
        end
        else if (xb_reg > CMAX)
        begin
            xc = CMAX;
            sat = 1'b1;
        end
        if (yb_reg < CMIN)
        begin
            yc = CMIN;
            sat = 1'b1;
        end
        else if (yb_reg > CMAX)
        begin
            yc = CMAX;
            sat = 1'b1;
        end
        if (wb_reg < 0)
        begin
            wc = '0;
            sat = 1'b1;
        end
        else if (wb_reg > CMAX)
        begin
            wc = CMAX;
            sat = 1'b1;
        end
        if (hb_reg < 0)
        begin
            hc = '0;
            sat = 1'b1;
        end
        else if (hb_reg > CMAX)
        begin
            hc = CMAX;
            sat = 1'b1;
        end
        rsp_next.rect_x      = xc[15:0];
        rsp_next.rect_y      = yc[15:0];
        rsp_next.rect_width  = wc[14:0];
        rsp_next.rect_height = hc[14:0];
        rsp_next.status      = sat ? ST_SAT : ST_OK;
        if (kb_reg == KIND_BAD || kb_reg == KIND_DIV0)
        begin
            rsp_next.rect_x      = '0;
            rsp_next.rect_y      = '0;
            rsp_next.rect_width  = '0;
            rsp_next.rect_height = '0;
            rsp_next.status      = (kb_reg == KIND_BAD) ? ST_BAD_MODE : ST_ZERO_DIV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench for content_scale_placement: drives placement requests, predicts each
// placed rectangle with its own model and checks every response in order.
// Depends on csp_pkg and the content_scale_placement RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csp_pkg::*;

    localparam int LATENCY = 35;
    localparam longint CMAX = 32767;
    localparam longint CMIN = -32768;
    localparam int LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    csp_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    csp_rsp_t rsp;

    csp_rsp_t expected_rects[$];
    int       mismatches;
    int       cycles;
    bit       sink_idle_on;
    int       sink_hold;

    content_scale_placement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock and run limit.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Computes the placed rectangle for one request.
    function automatic csp_rsp_t place_rect(csp_req_t r);
        longint bx, by, bw, bh, cw, ch, x, y, w, h;
        bit widex, div0, sat, bad;
        csp_rsp_t o;
        bx = r.bounds_x;
        by = r.bounds_y;
        bw = r.bounds_width;
        bh = r.bounds_height;
        cw = r.content_width;
        ch = r.content_height;
        widex = (cw * bh >= bw * ch);
        div0 = 0;
        bad = 0;
        sat = 0;
        x = 0; y = 0; w = 0; h = 0;
        // kind: 0 fill, 1 center, 2 scale x, 3 scale y
        begin
            int kind;
            kind = 1;
            case (r.scale_mode)
                MODE_FILL:       kind = 0;
                MODE_CENTER:     kind = 1;
                MODE_FIT_ASPECT: kind = widex ? 2 : 3;
                MODE_COVER_CLIP: kind = widex ? 3 : 2;
                MODE_FIT_CENTER: kind = (cw <= bw && ch <= bh) ? 1 : (widex ? 2 : 3);
                MODE_FILL_X:     kind = 2;
                MODE_FIT_X:      kind = (cw <= bw) ? 1 : 2;
                MODE_FILL_Y:     kind = 3;
                MODE_FIT_Y:      kind = (ch <= bh) ? 1 : 3;
                default:         bad = 1;
            endcase
            if (!bad)
            begin
                case (kind)
                    0: begin x = bx; y = by; w = bw; h = bh; end
                    1: begin w = cw; h = ch; end
                    2: if (cw == 0) div0 = 1; else begin w = bw; h = bw * ch / cw; end
                    default: if (ch == 0) div0 = 1; else begin w = cw * bh / ch; h = bh; end
                endcase
                if (kind != 0)
                begin
                    x = bx + (bw - w) / 2;
                    y = by + (bh - h) / 2;
                end
            end
        end
        o = '0;
        if (bad)
            o.status = ST_BAD_MODE;
        else if (div0)
            o.status = ST_ZERO_DIV;
        else
        begin
            if (x < CMIN) begin x = CMIN; sat = 1; end
            if (x > CMAX) begin x = CMAX; sat = 1; end
            if (y < CMIN) begin y = CMIN; sat = 1; end
            if (y > CMAX) begin y = CMAX; sat = 1; end
            if (w > CMAX) begin w = CMAX; sat = 1; end
            if (h > CMAX) begin h = CMAX; sat = 1; end
            o.rect_x = x[15:0];
            o.rect_y = y[15:0];
            o.rect_width = w[14:0];
            o.rect_height = h[14:0];
            o.status = sat ? ST_SAT : ST_OK;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Response side: random stalls, or a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b1;
        else if (sink_hold > 0)
        begin
            rsp_stall <= 1'b1;
            sink_hold <= sink_hold - 1;
        end
        else
            rsp_stall <= sink_idle_on ? ($urandom_range(99) < 12) : 1'b0;
    end

    // Checks each accepted response against the oldest expected rectangle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rects.size() == 0)
            begin
                report_mismatch("unexpected response", 1, 0);
            end
            else
            begin
                csp_rsp_t e;
                e = expected_rects.pop_front();
                if (rsp.rect_x !== e.rect_x) report_mismatch("rect_x", rsp.rect_x, e.rect_x);
                if (rsp.rect_y !== e.rect_y) report_mismatch("rect_y", rsp.rect_y, e.rect_y);
                if (rsp.rect_width !== e.rect_width)
                    report_mismatch("rect_width", rsp.rect_width, e.rect_width);
                if (rsp.rect_height !== e.rect_height)
                    report_mismatch("rect_height", rsp.rect_height, e.rect_height);
                if (rsp.status !== e.status) report_mismatch("status", rsp.status, e.status);
            end
        end
    end

    bit source_idle_on;

    // Sends one request, with an optional random gap before it. Valid stays
    // high after acceptance so the next request can follow without a gap.
    task automatic send_request(csp_req_t r);
        while (source_idle_on && $urandom_range(99) < 12)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        expected_rects.push_back(place_rect(r));
    endtask

    // Drops valid and waits until every expected response has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rects.size() != 0)
            @(posedge clk);
    endtask

    function automatic csp_req_t make_req(logic [3:0] m, int bx, int by,
                                          int bw, int bh, int cw, int ch);
        csp_req_t r;
        r.scale_mode = m;
        r.bounds_x = 16'(bx);
        r.bounds_y = 16'(by);
        r.bounds_width = 15'(bw);
        r.bounds_height = 15'(bh);
        r.content_width = 15'(cw);
        r.content_height = 15'(ch);
        return r;
    endfunction

    // Every mode, unknown modes, zero divisors and saturating extremes.
    task automatic test_directed();
        send_request(make_req(MODE_FILL, -32768, 32767, 32767, 0, 5, 5));
        send_request(make_req(MODE_CENTER, 100, 50, 200, 100, 40, 20));
        send_request(make_req(MODE_FIT_ASPECT, 0, 0, 320, 240, 640, 360));
        send_request(make_req(MODE_FIT_ASPECT, 0, 0, 320, 240, 100, 400));
        send_request(make_req(MODE_COVER_CLIP, 10, 10, 320, 240, 640, 360));
        send_request(make_req(MODE_COVER_CLIP, 0, 0, 320, 240, 0, 10));
        send_request(make_req(MODE_FIT_CENTER, 0, 0, 320, 240, 30, 20));
        send_request(make_req(MODE_FIT_CENTER, 0, 0, 320, 240, 900, 20));
        send_request(make_req(MODE_FILL_X, 0, 0, 320, 240, 0, 10));
        send_request(make_req(MODE_FILL_X, 32767, 32767, 32767, 1, 1, 32767));
        send_request(make_req(MODE_FIT_X, 0, 0, 320, 240, 100, 7));
        send_request(make_req(MODE_FIT_X, 0, 0, 320, 240, 400, 7));
        send_request(make_req(MODE_FILL_Y, 0, 0, 320, 240, 10, 0));
        send_request(make_req(MODE_FILL_Y, -32768, -32768, 1, 32767, 32767, 1));
        send_request(make_req(MODE_FIT_Y, 0, 0, 320, 240, 7, 100));
        send_request(make_req(MODE_FIT_Y, 0, 0, 320, 240, 7, 0));
        send_request(make_req(MODE_FIT_Y, 0, 0, 320, 0, 7, 0));
        send_request(make_req(4'd9, 1, 1, 1, 1, 1, 1));
        send_request(make_req(4'd15, -1, -1, 32767, 32767, 32767, 32767));
        send_request(make_req(MODE_CENTER, -32768, -32768, 0, 0, 32767, 32767));
        send_request(make_req(MODE_CENTER, -32768, 0, 0, 0, 0, 0));
        send_request(make_req(MODE_FIT_ASPECT, 0, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    function automatic int rand_size();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return $urandom_range(32767);
            2: return 32767 - $urandom_range(3);
            default: return $urandom_range(1000);
        endcase
    endfunction

    function automatic csp_req_t rand_req();
        csp_req_t r;
        r.scale_mode = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                       4'($urandom_range(8));
        r.bounds_x = 16'($urandom);
        r.bounds_y = 16'($urandom);
        r.bounds_width = 15'(rand_size());
        r.bounds_height = 15'(rand_size());
        r.content_width = 15'(rand_size());
        r.content_height = 15'(rand_size());
        return r;
    endfunction

    // Random requests; the middle stretch runs without any idling.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            sink_idle_on = !(i >= count / 3 && i < count / 2);
            source_idle_on = sink_idle_on;
            send_request(rand_req());
        end
        wait_drained();
    endtask

    // Long receiver hold-off so the pipeline fills and stalls its input.
    task automatic test_backpressure();
        sink_hold <= 120;
        source_idle_on = 0;
        for (int i = 0; i < 80; i++)
            send_request(rand_req());
        source_idle_on = 1;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cycles = 0;
        mismatches = 0;
        sink_hold = 0;
        sink_idle_on = 1;
        source_idle_on = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_random(120);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_rects.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
